// File: rtl/mrpp_pkg.sv
package mrpp_pkg;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    // Control packet types that get special handling
    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_PINGRESP = 4'd13;

    // Byte role codes
    localparam logic [2:0] ROLE_HEADER    = 3'd0;
    localparam logic [2:0] ROLE_LENGTH    = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
    localparam logic [2:0] ROLE_TOPIC     = 3'd3;
    localparam logic [2:0] ROLE_MSG_ID    = 3'd4;
    localparam logic [2:0] ROLE_BODY      = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LEN_LONG  = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_REFUSED   = 3'd3;
    localparam logic [2:0] ST_SHORT_PUB = 3'd4;

    localparam int LenW = 28;

    // One result per received byte
    typedef struct packed {
        logic [3:0]      packet_type;
        logic [3:0]      header_flags;
        logic [2:0]      byte_role;
        logic [7:0]      data_out;
        logic [LenW-1:0] remaining_length;
        logic [15:0]     topic_length;
        logic [15:0]     message_id;
        logic [1:0]      qos_level;
        logic            last_of_packet;
        logic [2:0]      status;
    } t_result;

endpackage

// File: rtl/mrpp_in_stage.sv
module mrpp_in_stage
    import mrpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,
    input  logic       i_take,
    output logic       o_vld,
    output logic [7:0] o_byte
);

    logic       r_vld;
    logic [7:0] r_byte;

    // Refill in the same cycle the held byte moves on
    assign o_tready = !r_vld || i_take;
    assign o_vld    = r_vld;
    assign o_byte   = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_byte <= i_tdata;
        end
    end

endmodule

// File: rtl/mrpp_decode.sv
module mrpp_decode
    import mrpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    t_phase          r_phase,   n_phase;
    logic [3:0]      r_type,    n_type;
    logic [3:0]      r_flags,   n_flags;
    logic [LenW-1:0] r_len,     n_len;
    logic [1:0]      r_digits,  n_digits;
    logic [LenW-1:0] r_pos,     n_pos;
    logic [15:0]     r_tl,      n_tl;
    logic [15:0]     r_mid,     n_mid;
    logic            r_ack_bad, n_ack_bad;

    logic [2:0]      role;
    logic            last;
    logic [2:0]      status;
    logic [4:0]      shift;
    logic [LenW:0]   pos_inc;
    logic            is_pub;
    logic            has_id;

    function automatic logic ack_check(input logic [3:0] ptype, input logic [3:0] flags,
                                       input logic [LenW-1:0] len);
        logic bad;
        bad = 1'b0;
        if (ptype == TYPE_CONNACK || ptype == TYPE_PUBACK) begin
            bad = (flags != 4'd0) || (len != LenW'(2));
        end else if (ptype == TYPE_SUBACK) begin
            bad = (flags != 4'd0) || (len < LenW'(3));
        end else if (ptype == TYPE_PINGRESP) begin
            bad = (flags != 4'd0) || (len != '0);
        end
        return bad;
    endfunction

    function automatic logic [2:0] end_status(input logic [3:0] ptype,
                                              input logic [LenW-1:0] len,
                                              input logic [15:0] tl,
                                              input logic [15:0] mid,
                                              input logic ack_bad);
        logic [2:0] st;
        st = ST_OK;
        if (ptype == TYPE_PUBLISH) begin
            if ({1'b0, len} < (LenW'(tl) + (LenW+1)'(4))) begin
                st = ST_SHORT_PUB;
            end
        end else if (ptype == TYPE_CONNACK || ptype == TYPE_PUBACK ||
                     ptype == TYPE_SUBACK || ptype == TYPE_PINGRESP) begin
            if (ack_bad) begin
                st = ST_MALFORMED;
            end else if (ptype == TYPE_CONNACK && mid[7:0] != 8'd0) begin
                st = ST_REFUSED;
            end
        end
        return st;
    endfunction

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_flags   = r_flags;
        n_len     = r_len;
        n_digits  = r_digits;
        n_pos     = r_pos;
        n_tl      = r_tl;
        n_mid     = r_mid;
        n_ack_bad = r_ack_bad;
        role      = ROLE_HEADER;
        last      = 1'b0;
        status    = ST_OK;
        shift     = ({3'b000, r_digits} << 3) - {3'b000, r_digits};
        pos_inc   = {1'b0, r_pos} + (LenW+1)'(1);
        unique case (r_phase)
            PH_LENGTH: begin
                role     = ROLE_LENGTH;
                n_len    = r_len + (LenW'(i_byte[6:0]) << shift);
                n_digits = r_digits + 2'd1;
                if (i_byte[7]) begin
                    if (r_digits == 2'd3) begin
                        status  = ST_LEN_LONG;
                        last    = 1'b1;
                        n_phase = PH_HEADER;
                    end
                end else begin
                    n_ack_bad = ack_check(r_type, r_flags, n_len);
                    n_pos     = '0;
                    if (n_len == '0) begin
                        last    = 1'b1;
                        status  = end_status(r_type, n_len, r_tl, r_mid, n_ack_bad);
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                role = ROLE_BODY;
                if (r_type == TYPE_PUBLISH) begin
                    if (r_pos < LenW'(2)) begin
                        role = ROLE_TOPIC_LEN;
                        n_tl = {r_tl[7:0], i_byte};
                    end else if ({1'b0, r_pos} < (LenW'(r_tl) + (LenW+1)'(2))) begin
                        role = ROLE_TOPIC;
                    end else if ({1'b0, r_pos} < (LenW'(r_tl) + (LenW+1)'(4))) begin
                        role  = ROLE_MSG_ID;
                        n_mid = {r_mid[7:0], i_byte};
                    end
                end else if (r_type == TYPE_PUBACK || r_type == TYPE_SUBACK ||
                             r_type == TYPE_CONNACK) begin
                    if (r_pos < LenW'(2)) begin
                        n_mid = {r_mid[7:0], i_byte};
                        if (r_type != TYPE_CONNACK) begin
                            role = ROLE_MSG_ID;
                        end
                    end
                end
                n_pos = pos_inc[LenW-1:0];
                if (pos_inc >= {1'b0, r_len}) begin
                    last    = 1'b1;
                    status  = end_status(r_type, r_len, n_tl, n_mid, r_ack_bad);
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                role      = ROLE_HEADER;
                n_type    = i_byte[7:4];
                n_flags   = i_byte[3:0];
                n_len     = '0;
                n_digits  = 2'd0;
                n_pos     = '0;
                n_tl      = 16'd0;
                n_mid     = 16'd0;
                n_ack_bad = 1'b0;
                n_phase   = PH_LENGTH;
            end
        endcase
    end

    assign is_pub = (n_type == TYPE_PUBLISH);
    assign has_id = is_pub || n_type == TYPE_PUBACK || n_type == TYPE_SUBACK;

    always_comb begin
        o_result.packet_type      = n_type;
        o_result.header_flags     = n_flags;
        o_result.byte_role        = role;
        o_result.data_out         = i_byte;
        o_result.remaining_length = n_len;
        o_result.topic_length     = is_pub ? n_tl : 16'd0;
        o_result.message_id       = has_id ? n_mid : 16'd0;
        o_result.qos_level        = is_pub ? n_flags[2:1] : 2'd0;
        o_result.last_of_packet   = last;
        o_result.status           = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_type    <= 4'd0;
            r_flags   <= 4'd0;
            r_len     <= '0;
            r_digits  <= 2'd0;
            r_pos     <= '0;
            r_tl      <= 16'd0;
            r_mid     <= 16'd0;
            r_ack_bad <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_flags   <= n_flags;
            r_len     <= n_len;
            r_digits  <= n_digits;
            r_pos     <= n_pos;
            r_tl      <= n_tl;
            r_mid     <= n_mid;
            r_ack_bad <= n_ack_bad;
        end
    end

    // A packet body is only entered with a nonzero length
    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_len != '0))
        else $error("body phase with zero remaining length");

    // Errors are only reported on the closing byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.status != ST_OK) |-> o_result.last_of_packet)
        else $error("nonzero status off the last byte");

    // After the closing byte the next byte is a header byte
    a_last_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_result.last_of_packet) |=> (r_phase == PH_HEADER))
        else $error("no return to header after last byte");

endmodule

// File: rtl/mrpp_out_stage.sv
module mrpp_out_stage
    import mrpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_result,
    output logic    o_take,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_result o_result
);

    logic    r_vld;
    t_result r_result;

    // Move a new result in when the register is empty or being drained
    assign o_take   = i_vld && (!r_vld || i_tready);
    assign o_tvalid = r_vld;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= 1'b1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/mqtt_receive_packet_parser.sv
// Channel   Dir  Data bits                 Side bits
// s_axis    in   tdata[7:0]  byte_in       -
// m_axis    out  tdata[87:0] (see below)   tuser[2:0] byte_role, tlast last_of_packet
//
// One received byte enters per cycle while m_axis is not stalled, and yields
// one result transaction: input register, then decode into the result register.
// The whole state update for a byte is one pass through the decoder, so a
// byte can be taken every cycle while the result register drains.
// Reset (i_rst_n low, synchronous) empties both registers and puts the
// parser back at a header byte.
// A stall on m_axis holds the result register; the input register then fills
// and s_axis tready drops until the result is taken.
module mqtt_receive_packet_parser
    import mrpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] packet_type, [7:4] header_flags, [15:8] data_out,
    // [43:16] remaining_length, [59:44] topic_length, [75:60] message_id,
    // [77:76] qos_level, [80:78] status, [87:81] zero
    output logic [87:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] byte_role
    output logic        o_m_axis_tlast    // last_of_packet
);

    logic       in_vld;
    logic [7:0] in_byte;
    logic       take;
    t_result    dec_result;
    t_result    out_result;

    // Input register: holds one byte until the decoder can use it
    mrpp_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_take   (take),
        .o_vld    (in_vld),
        .o_byte   (in_byte)
    );

    // Framing state and per-byte decode; state advances only on take
    mrpp_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (in_byte),
        .o_result (dec_result)
    );

    // Result register facing the output stream
    mrpp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (in_vld),
        .i_result (dec_result),
        .o_take   (take),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_result (out_result)
    );

    // Pack the result fields, lowest field first
    assign o_m_axis_tdata = {7'd0,
                             out_result.status,
                             out_result.qos_level,
                             out_result.message_id,
                             out_result.topic_length,
                             out_result.remaining_length,
                             out_result.data_out,
                             out_result.header_flags,
                             out_result.packet_type};
    assign o_m_axis_tuser = out_result.byte_role;
    assign o_m_axis_tlast = out_result.last_of_packet;

endmodule
